@@ rtl/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// common clocking and reset qualification
`define CHK_CLOCKING @(posedge clk) disable iff (!rst_n)

// labelled concurrent assertion reporting by $error
`define CHK_ASSERT(label, prop, msg) \
    label: assert property (`CHK_CLOCKING prop) else $error(msg);

`endif

@@ rtl/bbpp_pkg.sv @@
`timescale 1ns / 1ps

package bbpp_pkg;

    // sdnv byte limit and largest accepted length width
    localparam int MAX_SDNV_BYTES = 10;
    localparam int LENGTH_BITS    = 32;

    // accumulator after one more 7-bit group of a length sdnv
    localparam int LEN_NEXT_W = 32 + 7;

    // count at which a continuing sdnv byte is one too many
    localparam logic [3:0] SDNV_LAST = 4'(MAX_SDNV_BYTES - 1);

    // phase of the parser, equal to the class of the byte it expects
    typedef enum logic [1:0] {
        PH_TYPE    = 2'd0,
        PH_FLAGS   = 2'd1,
        PH_LENGTH  = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_LENGTH   = 2'd1,
        ERR_FLAGS    = 2'd2,
        ERR_TOO_LONG = 2'd3
    } err_t;

    typedef struct packed {
        logic [1:0]  byte_class;
        logic [7:0]  block_kind;
        logic [63:0] block_flags;
        logic [31:0] payload_len;
        logic        header_done;
        logic [7:0]  payload_byte;
        logic        block_complete;
        logic [1:0]  error_code;
    } result_t;

endpackage

@@ rtl/bbpp_in_if.sv @@
`timescale 1ns / 1ps

interface bbpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

@@ rtl/bbpp_out_if.sv @@
`timescale 1ns / 1ps

interface bbpp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  byte_class;
    logic [7:0]  block_kind;
    logic [63:0] block_flags;
    logic [31:0] payload_len;
    logic        header_done;
    logic [7:0]  payload_byte;
    logic        block_complete;
    logic [1:0]  error_code;

    modport source (
        output valid, input ready,
        output byte_class, output block_kind, output block_flags, output payload_len,
        output header_done, output payload_byte, output block_complete, output error_code
    );
    modport sink (
        input valid, output ready,
        input byte_class, input block_kind, input block_flags, input payload_len,
        input header_done, input payload_byte, input block_complete, input error_code
    );
endinterface

@@ rtl/bundle_block_preamble_parser_unit.sv @@
`timescale 1ns / 1ps

// bundle extension block preamble parser
// rx: one stream byte per item (valid/ready). tx: one result item per byte,
// giving the byte class, block type, decoded flags and data length, header
// and block completion marks, the payload byte and an error code.
// a byte is parsed in the cycle it is accepted and its result is held in
// the output register from the next cycle; one item per cycle while tx
// takes results. the critical path is the 39-bit length compare feeding
// the result register.
// rx.ready is high whenever the output register is empty or being emptied
// in the same cycle, so bytes stream back to back while tx takes results.
// if tx stalls, the held result stays put and rx.ready drops until it goes.
// reset empties the output register and puts the parser back to awaiting a
// type byte with all decoded fields cleared.
// an overlong sdnv, a flags value beyond 64 bits or a length beyond
// LENGTH_BITS gives an error result and restarts at a type byte.
module bundle_block_preamble_parser_unit (
    input logic        clk,
    input logic        rst_n,
    bbpp_in_if.sink    rx,
    bbpp_out_if.source tx
);
    import bbpp_pkg::*;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [63:0] accum_reg, accum_next;
    logic [3:0]  nbytes_reg, nbytes_next;
    logic [7:0]  kind_reg, kind_next;
    logic [63:0] flags_reg, flags_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] remaining_reg, remaining_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    result_t     res_reg, res_next;

    logic                  accept;
    logic                  more;
    logic [6:0]            grp;
    logic                  too_long;
    logic                  flags_ovf;
    logic [LEN_NEXT_W-1:0] len_cand;
    logic                  len_ovf;
    logic [31:0]           rem_dec;
    logic                  hdr;
    logic                  done;
    err_t                  err;

    assign rx.ready = !out_valid_reg || tx.ready;
    assign accept   = rx.valid && rx.ready;

    assign more      = rx.in_byte[7];
    assign grp       = rx.in_byte[6:0];
    // a continuation flag on the last allowed byte
    assign too_long  = more && (nbytes_reg >= SDNV_LAST);
    // flags value would lose set bits on the next shift
    assign flags_ovf = |accum_reg[63:57];
    // a length sdnv never holds more than 32 bits before this byte
    assign len_cand  = {accum_reg[31:0], grp};
    assign len_ovf   = |len_cand[LEN_NEXT_W-1:LENGTH_BITS];
    assign rem_dec   = (remaining_reg == 32'd0) ? 32'd0 : remaining_reg - 32'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        accum_next     = accum_reg;
        nbytes_next    = nbytes_reg;
        kind_next      = kind_reg;
        flags_next     = flags_reg;
        length_next    = length_reg;
        remaining_next = remaining_reg;
        hdr            = 1'b0;
        done           = 1'b0;
        err            = ERR_NONE;

        case (phase_reg)
            PH_TYPE:
            begin
                kind_next      = rx.in_byte;
                flags_next     = 64'd0;
                length_next    = 32'd0;
                remaining_next = 32'd0;
                accum_next     = 64'd0;
                nbytes_next    = 4'd0;
                phase_next     = PH_FLAGS;
            end
            PH_FLAGS:
            begin
                if (flags_ovf)
                begin
                    err = ERR_FLAGS;
                end
                else if (too_long)
                begin
                    err = ERR_TOO_LONG;
                end
                else
                begin
                    accum_next  = {accum_reg[56:0], grp};
                    nbytes_next = nbytes_reg + 4'd1;
                    if (!more)
                    begin
                        flags_next  = {accum_reg[56:0], grp};
                        accum_next  = 64'd0;
                        nbytes_next = 4'd0;
                        phase_next  = PH_LENGTH;
                    end
                end
            end
            PH_LENGTH:
            begin
                if (len_ovf)
                begin
                    err = ERR_LENGTH;
                end
                else if (too_long)
                begin
                    err = ERR_TOO_LONG;
                end
                else
                begin
                    accum_next  = 64'(len_cand);
                    nbytes_next = nbytes_reg + 4'd1;
                    if (!more)
                    begin
                        length_next    = len_cand[31:0];
                        remaining_next = len_cand[31:0];
                        accum_next     = 64'd0;
                        nbytes_next    = 4'd0;
                        hdr            = 1'b1;
                        // empty payload ends the block on the header
                        if (len_cand[31:0] == 32'd0)
                        begin
                            done       = 1'b1;
                            phase_next = PH_TYPE;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_PAYLOAD:
            begin
                remaining_next = rem_dec;
                if (rem_dec == 32'd0)
                begin
                    done       = 1'b1;
                    phase_next = PH_TYPE;
                end
            end
            default:
            begin
                phase_next = PH_TYPE;
            end
        endcase

        if (err != ERR_NONE)
        begin
            accum_next  = 64'd0;
            nbytes_next = 4'd0;
            phase_next  = PH_TYPE;
        end

        res_next.byte_class     = phase_reg;
        res_next.block_kind     = kind_next;
        res_next.block_flags    = flags_next;
        res_next.payload_len    = length_next;
        res_next.header_done    = hdr;
        res_next.payload_byte   = (phase_reg == PH_PAYLOAD) ? rx.in_byte : 8'd0;
        res_next.block_complete = done;
        res_next.error_code     = err;

        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (tx.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TYPE;
            accum_reg     <= 64'd0;
            nbytes_reg    <= 4'd0;
            kind_reg      <= 8'd0;
            flags_reg     <= 64'd0;
            length_reg    <= 32'd0;
            remaining_reg <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg     <= phase_next;
                accum_reg     <= accum_next;
                nbytes_reg    <= nbytes_next;
                kind_reg      <= kind_next;
                flags_reg     <= flags_next;
                length_reg    <= length_next;
                remaining_reg <= remaining_next;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign tx.valid          = out_valid_reg;
    assign tx.byte_class     = res_reg.byte_class;
    assign tx.block_kind     = res_reg.block_kind;
    assign tx.block_flags    = res_reg.block_flags;
    assign tx.payload_len    = res_reg.payload_len;
    assign tx.header_done    = res_reg.header_done;
    assign tx.payload_byte   = res_reg.payload_byte;
    assign tx.block_complete = res_reg.block_complete;
    assign tx.error_code     = res_reg.error_code;

endmodule

@@ rtl/bbpp_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bbpp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rx_valid,
    input logic        rx_ready,
    input logic        tx_valid,
    input logic        tx_ready,
    input logic [1:0]  byte_class,
    input logic        header_done,
    input logic        block_complete,
    input logic [1:0]  error_code
);
    import bbpp_pkg::*;

    // a stalled result holds
    `CHK_ASSERT(a_tx_hold, tx_valid && !tx_ready |=> tx_valid && $stable(byte_class), "result dropped under stall")

    // every accepted byte shows a result next cycle
    `CHK_ASSERT(a_result_follows, rx_valid && rx_ready |=> tx_valid, "accepted item gave no result")

    // an error result never completes anything
    `CHK_ASSERT(a_err_no_done, tx_valid && error_code != ERR_NONE |-> !header_done && !block_complete, "error result marked complete")

    // header ends only on a length byte
    `CHK_ASSERT(a_hdr_class, tx_valid && header_done |-> byte_class == PH_LENGTH, "header done on wrong class")

endmodule

bind bundle_block_preamble_parser_unit bbpp_checker u_bbpp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rx_valid       (rx.valid),
    .rx_ready       (rx.ready),
    .tx_valid       (tx.valid),
    .tx_ready       (tx.ready),
    .byte_class     (tx.byte_class),
    .header_done    (tx.header_done),
    .block_complete (tx.block_complete),
    .error_code     (tx.error_code)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import bbpp_pkg::*;

    // largest data length the parser takes, capped at 32 bits
    localparam logic [63:0] LEN_MAX = (LENGTH_BITS >= 32) ? 64'hFFFF_FFFF
                                                          : (64'd1 << LENGTH_BITS) - 64'd1;
    localparam int ITEM_TARGET = 1750;
    localparam int DRAIN_LIMIT = 20000;

    // mirror of the parser: follows every accepted byte and queues the
    // result item it must give, then matches result items as they arrive
    class preamble_tracker;
        phase_t      ph;
        logic [63:0] accum;
        logic [3:0]  group_cnt;
        logic [7:0]  kind;
        logic [63:0] flags;
        logic [31:0] length;
        logic [31:0] left;
        result_t     expected_results[$];
        int unsigned errors;
        int unsigned results_seen;

        function new();
            ph = PH_TYPE;
            accum = '0;
            group_cnt = '0;
            kind = '0;
            flags = '0;
            length = '0;
            left = '0;
            errors = 0;
            results_seen = 0;
        endfunction

        function void note_byte(logic [7:0] b);
            result_t     r;
            logic        more;
            logic [63:0] grp;
            logic [63:0] nxt;
            err_t        e;
            more = b[7];
            grp = {57'd0, b[6:0]};
            e = ERR_NONE;
            r = '0;
            r.byte_class = ph;
            case (ph)
                PH_TYPE:
                begin
                    kind = b;
                    flags = '0;
                    length = '0;
                    left = '0;
                    accum = '0;
                    group_cnt = '0;
                    ph = PH_FLAGS;
                end
                PH_FLAGS:
                begin
                    if (accum[63:57] != 7'd0)
                        e = ERR_FLAGS;
                    else if (more && int'(group_cnt) + 1 >= MAX_SDNV_BYTES)
                        e = ERR_TOO_LONG;
                    else
                    begin
                        accum = (accum << 7) | grp;
                        group_cnt = group_cnt + 4'd1;
                        if (!more)
                        begin
                            flags = accum;
                            accum = '0;
                            group_cnt = '0;
                            ph = PH_LENGTH;
                        end
                    end
                end
                PH_LENGTH:
                begin
                    nxt = (accum << 7) | grp;
                    if (nxt > LEN_MAX)
                        e = ERR_LENGTH;
                    else if (more && int'(group_cnt) + 1 >= MAX_SDNV_BYTES)
                        e = ERR_TOO_LONG;
                    else
                    begin
                        accum = nxt;
                        group_cnt = group_cnt + 4'd1;
                        if (!more)
                        begin
                            length = nxt[31:0];
                            left = length;
                            accum = '0;
                            group_cnt = '0;
                            r.header_done = 1'b1;
                            if (left == 32'd0)
                            begin
                                r.block_complete = 1'b1;
                                ph = PH_TYPE;
                            end
                            else
                                ph = PH_PAYLOAD;
                        end
                    end
                end
                default:
                begin
                    r.payload_byte = b;
                    if (left != 32'd0)
                        left = left - 32'd1;
                    if (left == 32'd0)
                    begin
                        r.block_complete = 1'b1;
                        ph = PH_TYPE;
                    end
                end
            endcase
            if (e != ERR_NONE)
            begin
                accum = '0;
                group_cnt = '0;
                ph = PH_TYPE;
            end
            r.block_kind = kind;
            r.block_flags = flags;
            r.payload_len = length;
            r.error_code = e;
            expected_results = {expected_results, r};
        endfunction

        function void match(string field, logic [63:0] want, logic [63:0] seen);
            if (want !== seen)
            begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, field, want, seen);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            results_seen++;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t ns: result item with no byte behind it, expected none, actual %0h",
                         $time, got);
                return;
            end
            want = expected_results.pop_front();
            match("byte_class", 64'(want.byte_class), 64'(got.byte_class));
            match("block_kind", 64'(want.block_kind), 64'(got.block_kind));
            match("block_flags", want.block_flags, got.block_flags);
            match("payload_len", 64'(want.payload_len), 64'(got.payload_len));
            match("header_done", 64'(want.header_done), 64'(got.header_done));
            match("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
            match("block_complete", 64'(want.block_complete), 64'(got.block_complete));
            match("error_code", 64'(want.error_code), 64'(got.error_code));
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    bbpp_in_if  rx();
    bbpp_out_if tx();

    bundle_block_preamble_parser_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .tx    (tx)
    );

    preamble_tracker tracker = new();

    // bytes of the block being built, drained by send_block
    logic [7:0] block_bytes[$];
    int         items_sent = 0;
    bit         send_calm = 1'b0;
    int         send_calm_left = 150;

    // 4 ns clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // idle length: mostly none or short, now and then long; none at all in calm stretches
    function automatic int idle_gap(bit calm);
        int pick;
        if (calm)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // random value of w low bits
    function automatic logic [63:0] rand_bits(int w);
        logic [63:0] r;
        r = {$urandom, $urandom};
        if (w < 64)
            r = r & ((64'd1 << w) - 64'd1);
        return r;
    endfunction

    // fewest 7-bit groups that hold v
    function automatic int sdnv_groups(logic [63:0] v);
        int n;
        n = 1;
        while (n < 10 && (v >> (7 * n)) != 64'd0)
            n++;
        return n;
    endfunction

    // one more byte at the tail of the block being built
    function automatic void add_byte(logic [7:0] b);
        block_bytes = {block_bytes, b};
    endfunction

    // big-endian sdnv of v over n groups, leading groups zero where n is over the minimum
    function automatic void add_sdnv(logic [63:0] v, int n);
        logic [63:0] grp;
        for (int i = n - 1; i >= 0; i--)
        begin
            grp = (v >> (7 * i)) & 64'h7F;
            add_byte({i > 0, grp[6:0]});
        end
    endfunction

    // sdnv group count with some padding now and then
    function automatic int padded_groups(logic [63:0] v);
        int g;
        g = sdnv_groups(v);
        if ($urandom_range(0, 99) < 15)
            g = g + $urandom_range(0, 10 - g);
        return g;
    endfunction

    // one byte on rx; entered and left at a falling edge. valid stays high
    // through back-to-back items and gets a single assignment per step
    task automatic send_byte(logic [7:0] b);
        int gap;
        if (send_calm_left == 0)
        begin
            send_calm = !send_calm;
            send_calm_left = $urandom_range(100, 400);
        end
        else
            send_calm_left--;
        gap = idle_gap(send_calm);
        if (gap > 0)
        begin
            rx.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx.valid <= 1'b1;
        rx.in_byte <= b;
        @(posedge clk);
        while (!rx.ready)
            @(posedge clk);
        tracker.note_byte(b);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_block();
        while (block_bytes.size() != 0)
            send_byte(block_bytes.pop_front());
    endtask

    // bring the parser back to a type byte: zero groups end any sdnv
    // (a zero length ends the block), payload is run out with random bytes
    task automatic realign();
        while (tracker.ph != PH_TYPE)
        begin
            if (tracker.ph == PH_PAYLOAD)
                send_byte(8'($urandom_range(0, 255)));
            else
                send_byte(8'h00);
        end
    endtask

    // well-formed block: random flags over any width, mostly short payloads
    task automatic good_block();
        logic [63:0] fl;
        logic [63:0] len;
        int          pick;
        add_byte(8'($urandom_range(0, 255)));
        fl = rand_bits($urandom_range(0, 64));
        add_sdnv(fl, padded_groups(fl));
        pick = $urandom_range(0, 99);
        if (pick < 70)
            len = 64'($urandom_range(0, 6));
        else if (pick < 95)
            len = 64'($urandom_range(7, 40));
        else
            len = 64'($urandom_range(41, 120));
        add_sdnv(len, padded_groups(len));
        repeat (int'(len))
            add_byte(8'($urandom_range(0, 255)));
        send_block();
    endtask

    // broken headers: each one ends in an error result
    task automatic bad_block();
        logic [63:0] fl;
        logic [63:0] len;
        add_byte(8'($urandom_range(0, 255)));
        case ($urandom_range(0, 3))
            0:
            begin
                // flags past 64 bits; tenth byte random, so overflow also meets an overlong sdnv
                add_byte(8'h80 | 8'($urandom_range(2, 127)));
                repeat (8)
                    add_byte(8'h80 | 8'($urandom_range(0, 127)));
                add_byte(8'($urandom_range(0, 255)));
            end
            1:
            begin
                // flags sdnv still continuing on its last allowed byte
                add_byte(8'h80 | 8'($urandom_range(0, 1)));
                repeat (9)
                    add_byte(8'h80 | 8'($urandom_range(0, 127)));
            end
            2:
            begin
                // length sdnv of zero groups that never ends
                fl = rand_bits($urandom_range(0, 20));
                add_sdnv(fl, sdnv_groups(fl));
                repeat (9)
                    add_byte(8'h80);
                add_byte(8'h80 | 8'($urandom_range(0, 127)));
            end
            default:
            begin
                // length beyond 32 bits
                fl = rand_bits($urandom_range(0, 20));
                add_sdnv(fl, sdnv_groups(fl));
                len = (64'($urandom_range(1, 7)) << 32) | 64'($urandom);
                add_sdnv(len, padded_groups(len));
            end
        endcase
        send_block();
    endtask

    // random bytes in any phase; a length byte is kept short and final so
    // that no payload runs for ever
    task automatic noise_burst();
        int n;
        n = $urandom_range(1, 8);
        repeat (n)
        begin
            if (tracker.ph == PH_LENGTH)
                send_byte(8'($urandom_range(0, 63)));
            else
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // result side: ready toggles at the falling edge in stretches, with one
    // long hold-off once some hundreds of results are through
    initial
    begin : sink_side
        int stall_left;
        int calm_left;
        bit calm;
        bit held_off;
        stall_left = 0;
        calm_left = 200;
        calm = 1'b0;
        held_off = 1'b0;
        tx.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm_left == 0)
            begin
                calm = !calm;
                calm_left = $urandom_range(100, 400);
            end
            else
                calm_left--;
            // long hold so the output register fills and rx stalls
            if (!held_off && tracker.results_seen >= 500)
            begin
                held_off = 1'b1;
                stall_left = 400;
            end
            if (stall_left > 0)
            begin
                tx.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                tx.ready <= 1'b1;
                stall_left = idle_gap(calm);
            end
        end
    end

    // results taken at the rising edge where valid and ready meet
    initial
    begin : result_side
        result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && tx.valid && tx.ready)
            begin
                got.byte_class = tx.byte_class;
                got.block_kind = tx.block_kind;
                got.block_flags = tx.block_flags;
                got.payload_len = tx.payload_len;
                got.header_done = tx.header_done;
                got.payload_byte = tx.payload_byte;
                got.block_complete = tx.block_complete;
                got.error_code = tx.error_code;
                tracker.check_result(got);
            end
        end
    end

    initial
    begin : stimulus
        int waited;
        int pick;
        rst_n = 1'b0;
        rx.valid = 1'b0;
        rx.in_byte = 8'h00;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero length: header and block end on the one length byte, top type value
        block_bytes = '{8'hFF, 8'h00, 8'h00};
        send_block();
        // two payload bytes at both extremes
        block_bytes = '{8'h00, 8'h7F, 8'h02, 8'hFF, 8'h00};
        send_block();
        // length reaching 2^32 on its fifth byte
        block_bytes = '{8'h5A, 8'h00, 8'h90, 8'h80, 8'h80, 8'h80, 8'h00};
        send_block();
        // all 64 flag bits set over the full ten bytes, then zero length
        block_bytes = '{8'hC3, 8'h81};
        repeat (8)
            add_byte(8'hFF);
        add_byte(8'h7F);
        add_byte(8'h00);
        send_block();

        // random part: mostly whole blocks, some broken headers and noise
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
                good_block();
            else if (pick < 90)
                bad_block();
            else
                noise_burst();
            realign();
        end

        // largest length, left unfinished at the very end since only three of its payload bytes are sent
        block_bytes = '{8'h3C, 8'h00, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h11, 8'hEE, 8'h00};
        send_block();
        rx.valid <= 1'b0;

        // drain, then keep waiting for any stray item
        waited = 0;
        while (tracker.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (tracker.pending() != 0)
            $display("%0t ns: %0d expected result items never arrived, expected 0 left, actual %0d",
                     $time, tracker.pending(), tracker.pending());
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("bundle_block_preamble_parser_unit regression: pass");
        else
            $display("bundle_block_preamble_parser_unit regression: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("bundle_block_preamble_parser_unit regression: fail");
        $finish;
    end

endmodule
